// ----- hw/rtl/binary_trie_address_allocator_core_assert.svh -----
// Assertion macros shared by the allocator RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BINARY_TRIE_ADDRESS_ALLOCATOR_CORE_ASSERT_SVH
`define BINARY_TRIE_ADDRESS_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bta_pkg.sv -----
// Shared types and constants of the binary trie address allocator.
// No dependencies; used by the controller, the datapath and the top level.
package bta_pkg;

  // Default size of the address space, in address bits.
  localparam int unsigned AddrBitsDefault = 8;

  // Fixed widths of the result fields.
  localparam int unsigned AddrFieldW = 8;
  localparam int unsigned FreeFieldW = 9;

  // Request kinds on the action input.
  localparam logic ActAlloc   = 1'b0;
  localparam logic ActRelease = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_DFREE = 2'd2
  } status_e;

  // Ways the current tree node register moves.
  typedef enum logic [2:0] {
    NODE_HOLD,
    NODE_LOAD,
    NODE_UP,
    NODE_SIB,
    NODE_DOWN
  } node_op_e;

  // Which node of the next node's neighborhood is read.
  typedef enum logic [1:0] {
    RD_SELF,
    RD_SIB,
    RD_LEFT
  } rd_sel_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LEAF,
    S_CLIMB,
    S_DOWN,
    S_PROP,
    S_REL,
    S_UNMARK
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    node_op_e node_op;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    logic     wr_data;
    logic     grant;
    logic     finish;
    status_e  fin_status;
    logic     clear;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_full;
    logic node_root;
    logic node_even;
    logic node_leaf;
    logic child_leaf;
    logic parent_root;
    logic space_full;
    logic clear_last;
  } dp_stat_t;

endpackage

// ----- hw/rtl/bta_ctrl.sv -----
// Controller of the allocator: sequences the tree walk one node per cycle.
// Depends on bta_pkg; drives the datapath through dp_cmd_t.
module bta_ctrl
  import bta_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     action_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          if (action_i == ActRelease) begin
            state_d = S_REL;
          end else if (!stat_i.space_full) begin
            state_d = S_LEAF;
          end
        end
      end
      S_LEAF: begin
        state_d = stat_i.rd_full ? S_CLIMB : S_PROP;
      end
      S_CLIMB: begin
        if (stat_i.node_root) begin
          state_d = S_DOWN;
        end else if (stat_i.node_even && !stat_i.rd_full) begin
          state_d = stat_i.node_leaf ? S_PROP : S_DOWN;
        end
      end
      S_DOWN: begin
        if (stat_i.child_leaf) state_d = S_PROP;
      end
      S_PROP: begin
        if (!stat_i.rd_full || stat_i.parent_root) state_d = S_IDLE;
      end
      S_REL: begin
        state_d = stat_i.rd_full ? S_UNMARK : S_IDLE;
      end
      S_UNMARK: begin
        if (stat_i.parent_root) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath commands for the current state.
  always_comb begin
    cmd_o            = '0;
    cmd_o.node_op    = NODE_HOLD;
    cmd_o.rd_sel     = RD_SELF;
    cmd_o.fin_status = ST_OK;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      S_IDLE: begin
        // Load the leaf of the request, or report a full space at once.
        if (start_i) begin
          if (action_i == ActAlloc && stat_i.space_full) begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = ST_FULL;
          end else begin
            cmd_o.node_op = NODE_LOAD;
            cmd_o.rd_en   = 1'b1;
          end
        end
      end
      S_LEAF: begin
        // A free preferred leaf is granted right here.
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_SIB;
        if (!stat_i.rd_full) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_data = 1'b1;
          cmd_o.grant   = 1'b1;
        end
      end
      S_CLIMB: begin
        // Walk up until a right sibling with a free address turns up.
        cmd_o.rd_en = 1'b1;
        if (stat_i.node_root) begin
          cmd_o.rd_sel = RD_LEFT;
        end else if (stat_i.node_even && !stat_i.rd_full) begin
          cmd_o.node_op = NODE_SIB;
          if (stat_i.node_leaf) begin
            cmd_o.rd_sel  = RD_SIB;
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_data = 1'b1;
            cmd_o.grant   = 1'b1;
          end else begin
            cmd_o.rd_sel = RD_LEFT;
          end
        end else begin
          cmd_o.node_op = NODE_UP;
          cmd_o.rd_sel  = RD_SIB;
        end
      end
      S_DOWN: begin
        // Descend to the leftmost subtree that is not full.
        cmd_o.node_op = NODE_DOWN;
        cmd_o.rd_en   = 1'b1;
        if (stat_i.child_leaf) begin
          cmd_o.rd_sel  = RD_SIB;
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_data = 1'b1;
          cmd_o.grant   = 1'b1;
        end else begin
          cmd_o.rd_sel = RD_LEFT;
        end
      end
      S_PROP: begin
        // Mark parents full while the sibling is full as well.
        if (stat_i.rd_full) begin
          cmd_o.node_op = NODE_UP;
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_data = 1'b1;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_sel  = RD_SIB;
          cmd_o.finish  = stat_i.parent_root;
        end else begin
          cmd_o.finish = 1'b1;
        end
      end
      S_REL: begin
        // Free the leaf, or report that it was not allocated.
        if (stat_i.rd_full) begin
          cmd_o.wr_en = 1'b1;
        end else begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_DFREE;
        end
      end
      S_UNMARK: begin
        // Every ancestor of a freed leaf is no longer full.
        cmd_o.node_op = NODE_UP;
        cmd_o.wr_en   = 1'b1;
        cmd_o.finish  = stat_i.parent_root;
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- hw/rtl/bta_datapath.sv -----
// Datapath of the allocator: tree flag memory, node register, counts, result register.
// Depends on bta_pkg and the assertion macro header.
`include "binary_trie_address_allocator_core_assert.svh"

module bta_datapath
  import bta_pkg::*;
#(
  parameter int unsigned AddrBits = AddrBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  action_i,
  input  logic [AddrFieldW-1:0] address_i,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  output logic                  result_valid_o,
  output logic [1:0]            status_o,
  output logic [AddrFieldW-1:0] granted_address_o,
  output logic [FreeFieldW-1:0] free_count_o,
  output logic                  is_empty_o
);

  localparam int unsigned NodeW = AddrBits + 1;
  localparam int unsigned Depth = 2 ** NodeW;
  localparam logic [NodeW-1:0] Space   = {1'b1, {AddrBits{1'b0}}};
  localparam logic [NodeW-1:0] NodeOne = NodeW'(1);

  // Heap-indexed full flags: node 1 is the root, leaves sit at Space and above.
  logic tree_mem [Depth];
  logic rd_q;

  logic [NodeW-1:0]    n_q, n_d;
  logic [NodeW-1:0]    mem_ra, mem_wa, clr_q;
  logic                mem_we, mem_wd;
  logic [AddrBits-1:0] grant_q;
  logic                action_q;
  logic [NodeW-1:0]    taken_q, taken_d;

  logic                  res_valid_q;
  status_e               res_status_q;
  logic [AddrFieldW-1:0] res_granted_q, res_granted_d;
  logic [FreeFieldW-1:0] res_free_q;
  logic                  res_empty_q;

  // Next tree node.
  always_comb begin
    case (cmd_i.node_op)
      NODE_LOAD: n_d = {1'b1, AddrBits'(address_i)};
      NODE_UP:   n_d = n_q >> 1;
      NODE_SIB:  n_d = n_q | NodeOne;
      NODE_DOWN: n_d = {n_q[AddrBits-1:0], rd_q};
      default:   n_d = n_q;
    endcase
  end

  // Read and write addresses of the flag memory.
  always_comb begin
    case (cmd_i.rd_sel)
      RD_SIB:  mem_ra = n_d ^ NodeOne;
      RD_LEFT: mem_ra = {n_d[AddrBits-1:0], 1'b0};
      default: mem_ra = n_d;
    endcase
    mem_we = cmd_i.wr_en | cmd_i.clear;
    mem_wa = cmd_i.clear ? clr_q : n_d;
    mem_wd = cmd_i.clear ? 1'b0 : cmd_i.wr_data;
  end

  // Flag memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) tree_mem[mem_wa] <= mem_wd;
    if (cmd_i.rd_en) rd_q <= tree_mem[mem_ra];
  end

  // Request payload and walk registers.
  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    if (cmd_i.node_op == NODE_LOAD) action_q <= action_i;
    if (cmd_i.grant) grant_q <= n_d[AddrBits-1:0];
  end

  // Allocation count after a finished request.
  always_comb begin
    taken_d = taken_q;
    if (cmd_i.finish && cmd_i.fin_status == ST_OK) begin
      taken_d = (action_q == ActRelease) ? taken_q - NodeOne : taken_q + NodeOne;
    end
    res_granted_d = '0;
    if (cmd_i.fin_status == ST_OK && action_q == ActAlloc) begin
      res_granted_d = AddrFieldW'(grant_q);
    end
  end

  // Clearing sweep counter, allocation count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      taken_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + NodeOne;
      taken_q     <= taken_d;
      res_valid_q <= cmd_i.finish;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_status_q  <= cmd_i.fin_status;
      res_granted_q <= res_granted_d;
      res_free_q    <= FreeFieldW'(Space - taken_d);
      res_empty_q   <= (taken_d == '0);
    end
  end

  // Status toward the controller.
  always_comb begin
    stat_o.rd_full     = rd_q;
    stat_o.node_root   = (n_q == NodeOne);
    stat_o.node_even   = !n_q[0];
    stat_o.node_leaf   = n_q[AddrBits];
    stat_o.child_leaf  = n_q[AddrBits-1];
    stat_o.parent_root = ((n_q >> 1) == NodeOne);
    stat_o.space_full  = (taken_q == Space);
    stat_o.clear_last  = &clr_q;
  end

  assign result_valid_o    = res_valid_q;
  assign status_o          = res_status_q;
  assign granted_address_o = res_granted_q;
  assign free_count_o      = res_free_q;
  assign is_empty_o        = res_empty_q;

  `BTA_ASSERT_SAME(a_alloc_not_full,
    cmd_i.finish && cmd_i.fin_status == ST_OK && action_q == ActAlloc,
    taken_q != Space, "allocate succeeded on a full space")
  `BTA_ASSERT_SAME(a_release_not_empty,
    cmd_i.finish && cmd_i.fin_status == ST_OK && action_q == ActRelease,
    taken_q != '0, "release succeeded with nothing allocated")
  `BTA_ASSERT_SAME(a_full_only_when_full,
    cmd_i.finish && cmd_i.fin_status == ST_FULL,
    taken_q == Space, "full reported while addresses are free")
  `BTA_ASSERT_NEXT(a_alloc_not_empty,
    cmd_i.finish && cmd_i.fin_status == ST_OK && action_q == ActAlloc,
    !res_empty_q, "empty flag set after a granted allocate")

endmodule

// ----- hw/rtl/binary_trie_address_allocator_core.sv -----
// Top level of the binary trie next-free address allocator.
// Depends on bta_pkg, bta_ctrl and bta_datapath.
//
//   channel   handshake                 payload
//   -------   -----------------------   ----------------------------------------------
//   request   start, busy               action_i, address_i
//   result    result_valid_o (strobe)   status_o, granted_address_o, free_count_o,
//                                       is_empty_o
//
// After reset a clearing pass writes every flag memory entry; busy is high throughout.
// The flag memory has one read and one write port, so a request walks one tree level
// per cycle; an allocate on a full space is reported while idle, without a walk.
// One request is in flight at a time; busy is high until its result is registered.
// The result strobe lasts one cycle and the receiver cannot stall it.
module binary_trie_address_allocator_core
  import bta_pkg::*;
#(
  parameter int unsigned AddrBits = AddrBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  action_i,
  input  logic [AddrFieldW-1:0] address_i,
  output logic                  result_valid_o,
  output logic [1:0]            status_o,
  output logic [AddrFieldW-1:0] granted_address_o,
  output logic [FreeFieldW-1:0] free_count_o,
  output logic                  is_empty_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Walk sequencer.
  bta_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // Flag memory, counters and result register.
  bta_datapath #(
    .AddrBits (AddrBits)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .action_i          (action_i),
    .address_i         (address_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .free_count_o      (free_count_o),
    .is_empty_o        (is_empty_o)
  );

endmodule
